// ===== sv/srs_pkg.sv =====
// shared types, codes and defaults for the sparse row store
package srs_pkg;

  localparam int ROW_W = 8;
  localparam int COL_W = 8;
  localparam int VAL_W = 64;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int VALUE_BITS_DEF  = 64;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ORDER = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             found;
    logic [1:0]       status;
  } out_item_t;

endpackage

// ===== sv/sparse_row_store_insert_lookup_core.sv =====
// compressed sparse row store: in-order insert and element lookup sequencer
// add: one row pointer write a cycle for each skipped row, then the entry write
// get: reads the row's start and end pointers, then scans its entries with one entry read port and one column compare
// refused add or get of a row not yet reached goes straight to the result; a stalled result adds its wait
// one item at a time; in_ready rises at the same edge that registers the result
// rst_n (synchronous, active low) clears control state only; only written entries are read
module sparse_row_store_insert_lookup_core #(
  parameter int MAX_ENTRIES = srs_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_ROWS    = srs_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS  = srs_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srs_pkg::out_item_t out_data
);

  // sizes
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int EA_W      = $clog2(MAX_ENTRIES);
  localparam int ROW_DEPTH = (MAX_ROWS < (1 << srs_pkg::ROW_W)) ? MAX_ROWS
                                                                : (1 << srs_pkg::ROW_W);
  localparam int RA_W      = (ROW_DEPTH > 2) ? $clog2(ROW_DEPTH) : 1;
  localparam int ENT_W     = srs_pkg::COL_W + VALUE_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL   = 3'd1;
  localparam logic [2:0] ST_GSTART = 3'd2;
  localparam logic [2:0] ST_GEND   = 3'd3;
  localparam logic [2:0] ST_GLOAD  = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  // storage: entry store holds {column, value}, row_end holds one end pointer per row
  logic [ENT_W-1:0] ent_mem [MAX_ENTRIES];
  logic [CNT_W-1:0] rend_mem [ROW_DEPTH];

  // control and datapath registers
  logic [2:0]                 state_r, state_nxt;
  srs_pkg::in_item_t          item_r, item_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;        // entries stored
  logic [srs_pkg::ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [srs_pkg::ROW_W-1:0]  k_r, k_nxt;            // row pointer fill index
  logic [CNT_W-1:0]           ptr_r, ptr_nxt;        // scan address
  logic [CNT_W-1:0]           end_r, end_nxt;        // scan limit
  logic                       pend_r, pend_nxt;      // entry read in flight
  srs_pkg::out_item_t         res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  srs_pkg::out_item_t         out_data_r, out_data_nxt;

  // memory ports
  logic                       ent_we;
  logic [EA_W-1:0]            ent_waddr;
  logic [ENT_W-1:0]           ent_wdata;
  logic [ENT_W-1:0]           ent_rdata_r;
  logic                       rend_we;
  logic [RA_W-1:0]            rend_waddr;
  logic [RA_W-1:0]            rend_raddr;
  logic [CNT_W-1:0]           rend_rdata_r;

  // decode of the incoming item
  logic in_acc;
  logic row_oob;
  logic store_full;
  logic col_hit;
  logic [srs_pkg::ROW_W-1:0] row_m1;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign row_oob    = (32'(in_data.row) >= 32'(MAX_ROWS));
  assign store_full = (cnt_r >= CNT_W'(MAX_ENTRIES));
  assign row_m1     = item_r.row - 8'd1;

  // row pointer read: start of the row first, then its end
  assign rend_raddr = (state_r == ST_GSTART) ? row_m1[RA_W-1:0] : item_r.row[RA_W-1:0];

  // the single column comparator, on the registered entry read
  assign col_hit = pend_r &&
                   (ent_rdata_r[ENT_W-1 -: srs_pkg::COL_W] == item_r.col);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    cur_row_nxt   = cur_row_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ent_we        = 1'b0;
    ent_waddr     = cnt_r[EA_W-1:0];
    ent_wdata     = {item_r.col, item_r.value[VALUE_BITS-1:0]};
    rend_we       = 1'b0;
    rend_waddr    = k_r[RA_W-1:0];

    // result leaves when taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt           = in_data;
          k_nxt              = cur_row_r;
          res_nxt.read_value = '0;
          res_nxt.found      = 1'b0;
          res_nxt.status     = srs_pkg::STAT_OK;
          if (in_data.cmd == srs_pkg::CMD_ADD) begin
            // out of order wins over full
            if (row_oob || (in_data.row < cur_row_r)) begin
              res_nxt.status = srs_pkg::STAT_ORDER;
              state_nxt      = ST_DONE;
            end else if (store_full) begin
              res_nxt.status = srs_pkg::STAT_FULL;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_FILL;
            end
          end else begin
            // rows above the current one hold nothing
            if (row_oob || (in_data.row > cur_row_r)) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_GSTART;
            end
          end
        end
      end
      ST_FILL: begin
        if (k_r < item_r.row) begin
          // close one skipped row
          rend_we = 1'b1;
          k_nxt   = k_r + 8'd1;
        end else begin
          ent_we      = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
          cur_row_nxt = item_r.row;
          state_nxt   = ST_DONE;
        end
      end
      ST_GSTART: begin
        // previous row's end pointer is being read
        state_nxt = ST_GEND;
      end
      ST_GEND: begin
        ptr_nxt   = (item_r.row == '0) ? '0 : rend_rdata_r;
        state_nxt = ST_GLOAD;
      end
      ST_GLOAD: begin
        // the current row ends at the fill count
        end_nxt   = (item_r.row == cur_row_r) ? cnt_r : rend_rdata_r;
        pend_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (col_hit) begin
          // earliest match wins
          res_nxt.read_value = 64'(ent_rdata_r[VALUE_BITS-1:0]);
          res_nxt.found      = 1'b1;
          pend_nxt           = 1'b0;
          state_nxt          = ST_DONE;
        end else if (ptr_r < end_r) begin
          ptr_nxt  = ptr_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cur_row_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_row_r   <= cur_row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    k_r        <= k_nxt;
    ptr_r      <= ptr_nxt;
    end_r      <= end_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // entry store, one write and one registered read
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_r <= ent_mem[ptr_r[EA_W-1:0]];
  end

  // row end pointers, one write and one registered read
  always_ff @(posedge clk) begin
    if (rend_we) begin
      rend_mem[rend_waddr] <= cnt_r;
    end
    rend_rdata_r <= rend_mem[rend_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result never reports a hit together with an error
  a_hit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.found && (out_data_r.status != srs_pkg::STAT_OK)))
    else $error("hit reported with error status");

  // fill count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond store size");

  // fill count only ever steps by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  // the current row never moves back
  a_row_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cur_row_r >= $past(cur_row_r)))
    else $error("current row decreased");

endmodule

// ===== sim/sparse_row_store_insert_lookup_core_tb.sv =====
// testbench for the sparse row store: insert/lookup items checked against a local predictor
`timescale 1ns / 1ps

module sparse_row_store_insert_lookup_core_tb;

  localparam int N_ENTRIES = srs_pkg::MAX_ENTRIES_DEF;
  localparam int N_ROWS    = srs_pkg::MAX_ROWS_DEF;
  // longest scan in this stimulus is a few dozen entries; wait well past it at the end
  localparam int DRAIN_CYCLES = 64;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  srs_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  srs_pkg::out_item_t out_data;

  sparse_row_store_insert_lookup_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // local copy of the csr store, updated as each item is accepted
  logic [63:0] store_val   [N_ENTRIES];
  logic [7:0]  store_col   [N_ENTRIES];
  logic [10:0] row_end_ptr [N_ROWS];
  logic [10:0] stored_cnt;
  logic [7:0]  cur_row;

  // results still owed by the block, newest at the front, oldest at the back
  srs_pkg::out_item_t pending_results[$];

  int err_cnt;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_cycles;

  // what the run reached
  int n_items;
  int n_inserted;
  int n_order_rej;
  int n_full_rej;
  int n_hits;
  int n_misses;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // first and one-past-last entry index of a row that is not above the current row
  function automatic void row_span(input int r, output int first, output int last);
    first = (r == 0) ? 0 : int'(row_end_ptr[r-1]);
    last  = (r == int'(cur_row)) ? int'(stored_cnt) : int'(row_end_ptr[r]);
  endfunction

  // apply one item to the local store and return the result the block should give
  function automatic srs_pkg::out_item_t csr_apply(input srs_pkg::in_item_t it);
    srs_pkg::out_item_t res;
    int                 first;
    int                 last;
    int                 k;
    res = '0;
    res.status = srs_pkg::STAT_OK;
    n_items++;
    if (it.cmd == srs_pkg::CMD_ADD) begin
      if (int'(it.row) >= N_ROWS || it.row < cur_row) begin
        // out of order beats full
        res.status = srs_pkg::STAT_ORDER;
        n_order_rej++;
      end else if (int'(stored_cnt) >= N_ENTRIES) begin
        res.status = srs_pkg::STAT_FULL;
        n_full_rej++;
      end else begin
        // close every row skipped over, including the one being left
        for (k = int'(cur_row); k < int'(it.row); k++) begin
          row_end_ptr[k] = stored_cnt;
        end
        cur_row = it.row;
        store_val[stored_cnt] = it.value;
        store_col[stored_cnt] = it.col;
        stored_cnt = stored_cnt + 1'b1;
        n_inserted++;
      end
    end else begin
      if (int'(it.row) < N_ROWS && it.row <= cur_row) begin
        row_span(int'(it.row), first, last);
        // earliest match wins when a column repeats
        for (k = first; k < last && !res.found; k++) begin
          if (store_col[k] == it.col) begin
            res.read_value = store_val[k];
            res.found      = 1'b1;
          end
        end
      end
      if (res.found) n_hits++;
      else n_misses++;
    end
    return res;
  endfunction

  function automatic srs_pkg::in_item_t make_item(input logic cmd, input int r, input int c,
                                                  input logic [63:0] v);
    srs_pkg::in_item_t it;
    it.cmd   = cmd;
    it.row   = r[7:0];
    it.col   = c[7:0];
    it.value = v;
    return it;
  endfunction

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // a column already stored in the row, or a random one when the row is empty
  function automatic int stored_col_of(input int r);
    int first;
    int last;
    row_span(r, first, last);
    if (first < last) return int'(store_col[$urandom_range(last - 1, first)]);
    return $urandom_range(255);
  endfunction

  // in-order row for the next insert: rows advance roughly one per four entries
  // so the last row is reached about when the store fills
  function automatic int next_add_row();
    int target;
    int step;
    int r;
    target = (int'(stored_cnt) + 8) / 4;
    step   = 0;
    if (int'(cur_row) < target && $urandom_range(1) == 1) step = $urandom_range(3, 1);
    else if ($urandom_range(63) == 0) step = $urandom_range(8, 4);
    else if ($urandom_range(15) == 0) step = 1;
    r = int'(cur_row) + step;
    if (r > N_ROWS - 1) r = N_ROWS - 1;
    return r;
  endfunction

  // mostly well-formed inserts while the store has room, lookups with real columns,
  // and a little noise: out-of-order inserts and lookups of rows not yet reached
  function automatic srs_pkg::in_item_t rand_item();
    int pick;
    int r;
    int c;
    pick = $urandom_range(99);
    c    = $urandom_range(255);
    if (int'(stored_cnt) < N_ENTRIES) begin
      if (pick < 84) begin
        r = next_add_row();
        // sometimes repeat a column of the row to build duplicates
        if ($urandom_range(9) == 0 && r == int'(cur_row)) c = stored_col_of(r);
        return make_item(srs_pkg::CMD_ADD, r, c, rand_value());
      end
      if (pick < 88 && cur_row != 0) begin
        return make_item(srs_pkg::CMD_ADD, $urandom_range(int'(cur_row) - 1), c,
                         rand_value());
      end
    end else if (pick < 40) begin
      // store full: in-order inserts get full, lower rows get out of order
      r = (pick < 20) ? int'(cur_row) : $urandom_range(255);
      if (r < int'(cur_row)) r = $urandom_range(int'(cur_row));
      return make_item(srs_pkg::CMD_ADD, r, c, rand_value());
    end
    if ($urandom_range(9) < 8) begin
      r = $urandom_range(int'(cur_row));
      if ($urandom_range(9) < 6) c = stored_col_of(r);
    end else begin
      r = $urandom_range(255);
    end
    return make_item(srs_pkg::CMD_GET, r, c, rand_value());
  endfunction

  // offer one item, hold it until taken, then record what it should produce
  task automatic send_item(input srs_pkg::in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_front(csr_apply(it));
    @(negedge clk);
  endtask

  // result side: random stalls, or a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // compare every accepted result with the oldest one owed
  always @(posedge clk) begin : result_check
    srs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: got value %h found %0d status %0d", $time,
                 out_data.read_value, out_data.found, out_data.status);
        err_cnt++;
      end else begin
        want = pending_results.pop_back();
        if (out_data.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %h, got %h", $time,
                   want.read_value, out_data.read_value);
          err_cnt++;
        end
        if (out_data.found !== want.found) begin
          $display("%0t: found mismatch: expected %0d, got %0d", $time,
                   want.found, out_data.found);
          err_cnt++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time,
                   want.status, out_data.status);
          err_cnt++;
        end
      end
    end
  end

  // lookups into an empty store: current row with no entries, and a row not reached
  task automatic test_empty_lookups();
    send_item(make_item(srs_pkg::CMD_GET, 0, 0, 64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 255, 255, '1));
    send_item(make_item(srs_pkg::CMD_GET, 0, 255, '1));
  endtask

  // first row with extreme columns and values, plus a duplicate column
  task automatic test_first_row();
    send_item(make_item(srs_pkg::CMD_ADD, 0, 0, '1));
    send_item(make_item(srs_pkg::CMD_ADD, 0, 255, 64'h0));
    send_item(make_item(srs_pkg::CMD_ADD, 0, 0, 64'h0123_4567_89ab_cdef));
    send_item(make_item(srs_pkg::CMD_GET, 0, 0, 64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 0, 255, 64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 0, 7, 64'h0));
  endtask

  // jump a row: the skipped row must read empty, the rows around it intact
  task automatic test_row_skip();
    send_item(make_item(srs_pkg::CMD_ADD, 2, 8'h55, 64'haaaa_aaaa_aaaa_aaaa));
    send_item(make_item(srs_pkg::CMD_ADD, 2, 8'haa, 64'h5555_5555_5555_5555));
    send_item(make_item(srs_pkg::CMD_GET, 1, 0, 64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 2, 8'haa, 64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 3, 8'h55, 64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 0, 0, 64'h0));
  endtask

  // inserts below the current row are refused and leave the store alone
  task automatic test_out_of_order();
    send_item(make_item(srs_pkg::CMD_ADD, 1, 8'h55, '1));
    send_item(make_item(srs_pkg::CMD_ADD, 0, 0, '1));
    send_item(make_item(srs_pkg::CMD_GET, 2, 8'h55, 64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 1, 8'h55, 64'h0));
  endtask

  // receiver stops for a long stretch while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_cycles = 300;
    repeat (8) send_item(rand_item());
  endtask

  task automatic test_random_phase(input int n, input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    repeat (n) send_item(rand_item());
  endtask

  // fill the store if the random part did not, then hit the full and precedence cases
  task automatic test_store_full();
    while (int'(stored_cnt) < N_ENTRIES) begin
      send_item(make_item(srs_pkg::CMD_ADD, next_add_row(), $urandom_range(255),
                          rand_value()));
    end
    send_item(make_item(srs_pkg::CMD_ADD, int'(cur_row), 3, '1));
    if (cur_row != 0) send_item(make_item(srs_pkg::CMD_ADD, int'(cur_row) - 1, 3, '1));
    send_item(make_item(srs_pkg::CMD_ADD, 255, 255, '1));
    send_item(make_item(srs_pkg::CMD_GET, int'(cur_row), stored_col_of(int'(cur_row)),
                        64'h0));
    send_item(make_item(srs_pkg::CMD_GET, 0, 0, 64'h0));
  endtask

  // let every owed result arrive, then watch a while for strays
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    err_cnt      = 0;
    hold_cycles  = 0;
    send_gap_pct = 30;
    recv_gap_pct = 86;
    stored_cnt   = '0;
    cur_row      = '0;
    n_items      = 0;
    n_inserted   = 0;
    n_order_rej  = 0;
    n_full_rej   = 0;
    n_hits       = 0;
    n_misses     = 0;
    foreach (row_end_ptr[i]) row_end_ptr[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_lookups();
    test_first_row();
    test_row_skip();
    test_out_of_order();
    test_output_backpressure();
    test_random_phase(440, 30, 86);
    test_random_phase(440, 86, 30);
    test_random_phase(440, 0, 0);
    test_store_full();
    drain();

    $display("covered %0d items: %0d inserts stored, %0d refused out of order, %0d full",
             n_items, n_inserted, n_order_rej, n_full_rej);
    $display("lookups: %0d hits, %0d misses; store ended at %0d entries, last row %0d",
             n_hits, n_misses, stored_cnt, cur_row);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sparse_row_store_insert_lookup_core.f =====
sv/srs_pkg.sv
sv/sparse_row_store_insert_lookup_core.sv
sim/sparse_row_store_insert_lookup_core_tb.sv
